/* rtl/core/dcfr_pkg.sv */
// ----------------------------------------------------------------------------
// dcfr_pkg
// Shared types and constants for the duty command frame receiver.
// ----------------------------------------------------------------------------
package dcfr_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 9;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SYNC_BYTE       = 2'd0,
		REG_SPEED_OFFSET    = 2'd1,
		REG_MAGNITUDE_LIMIT = 2'd2
	} reg_index_t;

	localparam logic [7:0] SYNC_BYTE_RST       = 8'hAA;
	localparam logic [7:0] SPEED_OFFSET_RST    = 8'd8;
	localparam logic [8:0] MAGNITUDE_LIMIT_RST = 9'd256;

	// scaling: command = round(mant * 2^k / 25), k = expo - 144 (normal)
	localparam logic [7:0]  EXPO_BIG     = 8'd144;  // k >= 0: far above any limit
	localparam logic [7:0]  EXPO_ALL_ONE = 8'hFF;
	localparam logic [7:0]  SHIFT_DENORM = 8'd143;
	localparam logic [7:0]  SHIFT_MAX    = 8'd40;
	// shifted value at or above this rounds to 512 or more
	localparam logic [24:0] T_BIG        = 25'd25575;
	localparam logic [14:0] HALF_DIV     = 15'd25;
	// floor(v / 25) = (v * RECIP_25) >> RECIP_SHIFT, exact for v < 43690
	localparam logic [14:0] RECIP_25     = 15'd20972;
	localparam int unsigned RECIP_SHIFT  = 19;

	localparam logic [9:0]  SPEED_MAX    = 10'd511;

	typedef struct packed {
		logic [7:0] speed_offset;
		logic [8:0] magnitude_limit;
	} scale_cfg_t;

endpackage

/* rtl/core/dcfr_if.sv */
// ----------------------------------------------------------------------------
// dcfr channel interfaces
// Valid/ready channels for received bytes, commands and register writes.
// ----------------------------------------------------------------------------
interface dcfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface dcfr_result_if;
	logic              valid;
	logic              ready;
	logic              direction_low;
	logic [8:0]        speed_value;
	logic signed [9:0] duty_command;

	modport source (output valid, output direction_low, output speed_value,
		output duty_command, input ready);
	modport sink   (input valid, input direction_low, input speed_value,
		input duty_command, output ready);
endinterface

interface dcfr_cfg_if;
	import dcfr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/dcfr_parser.sv */
// ----------------------------------------------------------------------------
// dcfr_parser
// Sync hunt and payload gather; holds a complete frame word in stage 1.
// ----------------------------------------------------------------------------
module dcfr_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  sync_byte,
	input  logic        take_s1,
	output logic        frame_valid_s1,
	output logic [31:0] frame_bits_s1
);
	import dcfr_pkg::*;

	typedef enum logic [5:0] {
		ST_HUNT0 = 6'b000001,
		ST_HUNT1 = 6'b000010,
		ST_PAY0  = 6'b000100,
		ST_PAY1  = 6'b001000,
		ST_PAY2  = 6'b010000,
		ST_PAY3  = 6'b100000
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  prev_q;
	logic [23:0] payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ST_HUNT0;
			prev_q  <= '0;
		end else if (accept) begin
			unique case (phase_q)
				ST_HUNT0: begin
					prev_q  <= data_byte;
					phase_q <= ST_HUNT1;
				end
				ST_HUNT1: begin
					if (prev_q == sync_byte && data_byte == sync_byte) begin
						phase_q <= ST_PAY0;
					end else begin
						prev_q <= data_byte;
					end
				end
				ST_PAY0: phase_q <= ST_PAY1;
				ST_PAY1: phase_q <= ST_PAY2;
				ST_PAY2: phase_q <= ST_PAY3;
				ST_PAY3: phase_q <= ST_HUNT0;
				default: phase_q <= ST_HUNT0;
			endcase
		end
	end

	// payload bytes, little endian
	always_ff @(posedge clk) begin
		if (accept) begin
			if (phase_q == ST_PAY0) payload_q[7:0]   <= data_byte;
			if (phase_q == ST_PAY1) payload_q[15:8]  <= data_byte;
			if (phase_q == ST_PAY2) payload_q[23:16] <= data_byte;
		end
	end

	logic frame_done;
	assign frame_done = accept && (phase_q == ST_PAY3);

	// a new frame wins over the take of the old one in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_s1 <= 1'b0;
		end else begin
			frame_valid_s1 <= frame_done || (frame_valid_s1 && !take_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (frame_done) frame_bits_s1 <= {data_byte, payload_q};
	end

endmodule

/* rtl/core/dcfr_scale.sv */
// ----------------------------------------------------------------------------
// dcfr_scale
// Float percentage to rounded, saturated duty command; output register.
// ----------------------------------------------------------------------------
module dcfr_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frame_valid_s1,
	input  logic [31:0]         frame_bits_s1,
	input  dcfr_pkg::scale_cfg_t scale_cfg,
	output logic                ready_s2,
	dcfr_result_if.source       cmd
);
	import dcfr_pkg::*;

	logic        sign;
	logic [7:0]  expo;
	logic [22:0] frac;
	logic [23:0] mant;
	logic [7:0]  shift;
	logic [24:0] t;
	logic [14:0] u;
	logic [28:0] prod;
	logic [8:0]  q;
	logic        big;
	logic [8:0]  mag;
	logic [9:0]  speed_sum;

	always_comb begin
		sign = frame_bits_s1[31];
		expo = frame_bits_s1[30:23];
		frac = frame_bits_s1[22:0];
		mant = {(expo != 8'd0), frac};
		shift = (expo == 8'd0) ? SHIFT_DENORM : (EXPO_BIG - expo);
		// round(mant / (25 * 2^s)) = floor((floor(2*mant / 2^s) + 25) / 50)
		t = (shift > SHIFT_MAX) ? 25'd0 : ({mant, 1'b0} >> shift[5:0]);
		big = (expo >= EXPO_BIG) || (t >= T_BIG);
		u = t[14:0] + HALF_DIV;
		prod = 29'(u[14:1]) * 29'(RECIP_25);
		q = prod[RECIP_SHIFT +: 9];
		if (expo == EXPO_ALL_ONE) begin
			mag = (frac != 23'd0) ? 9'd0 : scale_cfg.magnitude_limit;
		end else if (big || q > scale_cfg.magnitude_limit) begin
			mag = scale_cfg.magnitude_limit;
		end else begin
			mag = q;
		end
		speed_sum = 10'(scale_cfg.speed_offset) + 10'(mag);
	end

	assign ready_s2 = !cmd.valid || cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
		end else if (ready_s2) begin
			cmd.valid <= frame_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && frame_valid_s1) begin
			cmd.direction_low <= sign || (mag == 9'd0);
			cmd.speed_value   <= (speed_sum > SPEED_MAX) ? 9'd511 : speed_sum[8:0];
			cmd.duty_command  <= sign ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

endmodule

/* rtl/core/duty_command_frame_receiver.sv */
// ----------------------------------------------------------------------------
// duty_command_frame_receiver
// Hunts two sync bytes, gathers a little-endian float duty percentage and
// emits the rounded, saturated duty command with direction and speed.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                      | per transfer
//  --------+-----+----------------------------------------------+---------------
//  rx      | in  | data_byte[7:0]                               | one serial byte
//  cmd     | out | direction_low, speed_value[8:0],             | one command
//          |     | duty_command[9:0] signed                     |
//  cfg     | in  | index[1:0], data[8:0]                        | one reg write
//
//  One byte per cycle is taken while rx is ready. The frame's last byte
//  lands in stage 1 (frame register) at its transfer edge; the command is
//  then loaded into the output register once that register is free, and
//  cmd.valid rises with that load. rx stalls only while stage 1 holds a
//  frame and the output register is full and not being taken. cfg is
//  always ready. arst_n clears the hunt state, the valid flags and the
//  registers to their defaults (sync 0xAA, offset 8, limit 256).
//
module duty_command_frame_receiver (
	input  logic          clk,
	input  logic          arst_n,
	dcfr_byte_if.sink     rx,
	dcfr_result_if.source cmd,
	dcfr_cfg_if.sink      cfg
);
	import dcfr_pkg::*;

	// configuration registers
	logic [7:0] sync_byte_q;
	logic [7:0] speed_offset_q;
	logic [8:0] magnitude_limit_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_byte_q       <= SYNC_BYTE_RST;
			speed_offset_q    <= SPEED_OFFSET_RST;
			magnitude_limit_q <= MAGNITUDE_LIMIT_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_SYNC_BYTE:       sync_byte_q       <= cfg.data[7:0];
				REG_SPEED_OFFSET:    speed_offset_q    <= cfg.data[7:0];
				REG_MAGNITUDE_LIMIT: magnitude_limit_q <= cfg.data;
				default: ;  // writes past the register list are dropped
			endcase
		end
	end

	scale_cfg_t scale_cfg;
	assign scale_cfg.speed_offset    = speed_offset_q;
	assign scale_cfg.magnitude_limit = magnitude_limit_q;

	// stage handshake
	logic        frame_valid_s1;
	logic [31:0] frame_bits_s1;
	logic        ready_s2;
	logic        rx_accept;
	logic        take_s1;

	assign rx.ready  = !frame_valid_s1 || ready_s2;
	assign rx_accept = rx.valid && rx.ready;
	assign take_s1   = frame_valid_s1 && ready_s2;

	dcfr_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (rx_accept),
		.data_byte      (rx.data_byte),
		.sync_byte      (sync_byte_q),
		.take_s1        (take_s1),
		.frame_valid_s1 (frame_valid_s1),
		.frame_bits_s1  (frame_bits_s1)
	);

	dcfr_scale u_scale (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_valid_s1 (frame_valid_s1),
		.frame_bits_s1  (frame_bits_s1),
		.scale_cfg      (scale_cfg),
		.ready_s2       (ready_s2),
		.cmd            (cmd)
	);

	// ---- checks ----
	logic [9:0] cmd_abs;
	assign cmd_abs = cmd.duty_command[9] ? 10'(-cmd.duty_command) : cmd.duty_command;

	// direction follows the sign of the command
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid |-> (cmd.direction_low == (cmd.duty_command <= 10'sd0)))
		else $error("direction_low disagrees with duty_command");

	// command magnitude never exceeds the saturation bound
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid |-> (cmd_abs <= {1'b0, magnitude_limit_q}))
		else $error("duty_command beyond magnitude_limit");

	// speed is at least the magnitude (offset is non-negative)
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid |-> ({1'b0, cmd.speed_value} >= cmd_abs))
		else $error("speed_value below command magnitude");

	// a held frame is never overwritten by a new one
	assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid_s1 && !ready_s2) |-> !rx_accept)
		else $error("byte accepted while stage 1 is blocked");

endmodule
